FILE: rtl/core/c65_pkg.sv
// shared types and constants for the 6502 subset executor
`default_nettype none
package c65_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [15:0] START_RESET = 16'h8000;
    localparam logic [7:0]  FLAGS_RESET = 8'h24;
    localparam logic [7:0]  SP_RESET    = 8'hFD;
    localparam logic [7:0]  STACK_PAGE  = 8'h01;
    localparam logic [15:0] VEC_LO      = 16'hFFFE;
    localparam logic [15:0] VEC_HI      = 16'hFFFF;
    localparam logic [7:0]  FL_BRK_PUSH = 8'b0011_0000;

    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    typedef enum logic [4:0] {
        K_LOAD, K_BRK, K_ASL, K_JSR, K_JMP, K_BIT, K_ADC, K_ST, K_LD,
        K_INX, K_INY, K_CPX, K_BNE, K_BEQ, K_NOP, K_INC, K_UNS
    } t_kind;

    typedef enum logic [1:0] {R_A, R_X, R_Y} t_reg;

    typedef enum logic [3:0] {
        M_NONE, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY
    } t_mode;

    // decoded request as it waits between front and back
    typedef struct packed {
        t_kind      kind;
        t_reg       rsel;
        t_mode      mode;
        logic [1:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [7:0]  acc_value;
        logic [7:0]  x_value;
        logic [7:0]  y_value;
        logic [7:0]  flags_value;
        logic [7:0]  sp_value;
        logic        store_valid;
        logic [15:0] store_address;
        logic [7:0]  store_data;
        logic        unsupported;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/core/c65_if.sv
// request, result and configuration channel interfaces
`default_nettype none
interface c65_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [7:0] load_data;
    modport source (output valid, cmd, opcode, operand_low, operand_high, load_data,
                    input ready);
    modport sink (input valid, cmd, opcode, operand_low, operand_high, load_data,
                  output ready);
endinterface

interface c65_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_pc;
    logic [7:0]  acc_value;
    logic [7:0]  x_value;
    logic [7:0]  y_value;
    logic [7:0]  flags_value;
    logic [7:0]  sp_value;
    logic        store_valid;
    logic [15:0] store_address;
    logic [7:0]  store_data;
    logic        unsupported;
    modport source (output valid, next_pc, acc_value, x_value, y_value, flags_value,
                    sp_value, store_valid, store_address, store_data, unsupported,
                    input ready);
    modport sink (input valid, next_pc, acc_value, x_value, y_value, flags_value,
                  sp_value, store_valid, store_address, store_data, unsupported,
                  output ready);
endinterface

interface c65_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] start_address;
    modport source (output valid, start_address, input ready);
    modport sink (input valid, start_address, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/c65_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module c65_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wa,
    input  wire logic [WIDTH-1:0]         i_wd,
    input  wire logic [$clog2(DEPTH)-1:0] i_ra,
    output logic      [WIDTH-1:0]         o_rd
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end
endmodule
`default_nettype wire

FILE: rtl/core/c65_front.sv
// front end: opcode decode and two-entry queue toward the back end
`default_nettype none
module c65_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    c65_req_if.sink             i_req,
    input  wire logic           i_run,
    input  wire logic           i_pop,
    output logic                o_head_valid,
    output c65_pkg::t_item      o_head
);
    import c65_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      dec;
    logic       push;

    always_comb begin
        dec      = '0;
        dec.lo   = i_req.operand_low;
        dec.hi   = i_req.operand_high;
        dec.data = i_req.load_data;
        dec.kind = K_UNS;
        dec.rsel = R_A;
        dec.mode = M_NONE;
        dec.len  = 2'd1;
        if (i_req.cmd) begin
            dec.kind = K_LOAD;
        end else begin
            unique case (i_req.opcode)
                8'h00: begin dec.kind = K_BRK; dec.len = 2'd2; end
                8'h0A: begin dec.kind = K_ASL; end
                8'h20: begin dec.kind = K_JSR; dec.mode = M_ABS; end
                8'h4C: begin dec.kind = K_JMP; dec.mode = M_ABS; end
                8'h24: begin dec.kind = K_BIT; dec.mode = M_ZP;  dec.len = 2'd2; end
                8'h2C: begin dec.kind = K_BIT; dec.mode = M_ABS; dec.len = 2'd3; end
                8'h69: begin dec.kind = K_ADC; dec.mode = M_IMM;  dec.len = 2'd2; end
                8'h65: begin dec.kind = K_ADC; dec.mode = M_ZP;   dec.len = 2'd2; end
                8'h6D: begin dec.kind = K_ADC; dec.mode = M_ABS;  dec.len = 2'd3; end
                8'h61: begin dec.kind = K_ADC; dec.mode = M_INDX; dec.len = 2'd2; end
                8'h71: begin dec.kind = K_ADC; dec.mode = M_INDY; dec.len = 2'd2; end
                8'h84: begin dec.kind = K_ST; dec.rsel = R_Y; dec.mode = M_ZP;   dec.len = 2'd2; end
                8'h8C: begin dec.kind = K_ST; dec.rsel = R_Y; dec.mode = M_ABS;  dec.len = 2'd3; end
                8'h85: begin dec.kind = K_ST; dec.rsel = R_A; dec.mode = M_ZP;   dec.len = 2'd2; end
                8'h8D: begin dec.kind = K_ST; dec.rsel = R_A; dec.mode = M_ABS;  dec.len = 2'd3; end
                8'h95: begin dec.kind = K_ST; dec.rsel = R_A; dec.mode = M_ZPX;  dec.len = 2'd2; end
                8'h9D: begin dec.kind = K_ST; dec.rsel = R_A; dec.mode = M_ABSX; dec.len = 2'd3; end
                8'h86: begin dec.kind = K_ST; dec.rsel = R_X; dec.mode = M_ZP;   dec.len = 2'd2; end
                8'h8E: begin dec.kind = K_ST; dec.rsel = R_X; dec.mode = M_ABS;  dec.len = 2'd3; end
                8'hA0: begin dec.kind = K_LD; dec.rsel = R_Y; dec.mode = M_IMM;  dec.len = 2'd2; end
                8'hA4: begin dec.kind = K_LD; dec.rsel = R_Y; dec.mode = M_ZP;   dec.len = 2'd2; end
                8'hAC: begin dec.kind = K_LD; dec.rsel = R_Y; dec.mode = M_ABS;  dec.len = 2'd3; end
                8'hB4: begin dec.kind = K_LD; dec.rsel = R_Y; dec.mode = M_ZPX;  dec.len = 2'd2; end
                8'hA2: begin dec.kind = K_LD; dec.rsel = R_X; dec.mode = M_IMM;  dec.len = 2'd2; end
                8'hA6: begin dec.kind = K_LD; dec.rsel = R_X; dec.mode = M_ZP;   dec.len = 2'd2; end
                8'hAE: begin dec.kind = K_LD; dec.rsel = R_X; dec.mode = M_ABS;  dec.len = 2'd3; end
                8'hB6: begin dec.kind = K_LD; dec.rsel = R_X; dec.mode = M_ZPY;  dec.len = 2'd2; end
                8'hA9: begin dec.kind = K_LD; dec.rsel = R_A; dec.mode = M_IMM;  dec.len = 2'd2; end
                8'hA5: begin dec.kind = K_LD; dec.rsel = R_A; dec.mode = M_ZP;   dec.len = 2'd2; end
                8'hAD: begin dec.kind = K_LD; dec.rsel = R_A; dec.mode = M_ABS;  dec.len = 2'd3; end
                8'hA1: begin dec.kind = K_LD; dec.rsel = R_A; dec.mode = M_INDX; dec.len = 2'd2; end
                8'hB1: begin dec.kind = K_LD; dec.rsel = R_A; dec.mode = M_INDY; dec.len = 2'd2; end
                8'hB5: begin dec.kind = K_LD; dec.rsel = R_A; dec.mode = M_ZPX;  dec.len = 2'd2; end
                8'hB9: begin dec.kind = K_LD; dec.rsel = R_A; dec.mode = M_ABSY; dec.len = 2'd3; end
                8'hBD: begin dec.kind = K_LD; dec.rsel = R_A; dec.mode = M_ABSX; dec.len = 2'd3; end
                8'hC8: begin dec.kind = K_INY; end
                8'hE8: begin dec.kind = K_INX; end
                8'hE0: begin dec.kind = K_CPX; dec.mode = M_IMM; dec.len = 2'd2; end
                8'hD0: begin dec.kind = K_BNE; dec.len = 2'd2; end
                8'hF0: begin dec.kind = K_BEQ; dec.len = 2'd2; end
                8'hEA: begin dec.kind = K_NOP; end
                8'hE6: begin dec.kind = K_INC; dec.mode = M_ZP;   dec.len = 2'd2; end
                8'hEE: begin dec.kind = K_INC; dec.mode = M_ABS;  dec.len = 2'd3; end
                8'hF6: begin dec.kind = K_INC; dec.mode = M_ZPX;  dec.len = 2'd2; end
                8'hFE: begin dec.kind = K_INC; dec.mode = M_ABSX; dec.len = 2'd3; end
                default: begin dec.kind = K_UNS; end
            endcase
        end
    end

    assign i_req.ready  = i_run && (r_cnt != 2'd2);
    assign push         = i_req.valid && i_req.ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, i_pop});
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/c65_back.sv
// back end: architectural registers, data memory and the execute sequencer
`default_nettype none
module c65_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  c65_pkg::t_item      i_head,
    output logic                o_pop,
    output logic                o_run,
    c65_cfg_if.sink             i_cfg,
    c65_rsp_if.source           o_rsp
);
    import c65_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_DISP  = 9'b000000010,
        ST_PUSH1 = 9'b000000100,
        ST_PUSH2 = 9'b000001000,
        ST_VEC0  = 9'b000010000,
        ST_VEC1  = 9'b000100000,
        ST_PTRL  = 9'b001000000,
        ST_PTRH  = 9'b010000000,
        ST_MEMRD = 9'b100000000
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_a, n_a, r_x, n_x, r_y, n_y, r_p, n_p, r_sp, n_sp;
    logic [7:0]  r_ptr, n_ptr;
    logic [15:0] r_ea, n_ea;
    t_item       r_cur, n_cur;
    logic [MEM_AW-1:0] r_clr, n_clr;
    logic        r_ov, n_ov;
    t_result     r_out, n_out;

    logic              we;
    logic [MEM_AW-1:0] wa, ra;
    logic [7:0]        wd, rd;
    t_item             it;
    logic [15:0]       ea, abs16, p2, pc_seq, ind_ea;
    logic [7:0]        ptr, m, rv, sd, sum8;
    logic [8:0]        adc_s;
    logic              out_free, needs_rd, fin, sv;

    c65_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
        .i_clk (i_clk),
        .i_we  (we),
        .i_wa  (wa),
        .i_wd  (wd),
        .i_ra  (ra),
        .o_rd  (rd)
    );

    assign it       = (r_state == ST_DISP) ? i_head : r_cur;
    assign abs16    = {it.hi, it.lo};
    assign p2       = 16'(r_pc + 16'd2);
    assign pc_seq   = 16'(r_pc + {14'd0, it.len});
    assign ptr      = (it.mode == M_INDX) ? 8'(it.lo + r_x) : it.lo;
    assign ind_ea   = 16'({rd, r_ptr} + ((it.mode == M_INDY) ? {8'd0, r_y} : 16'd0));
    assign out_free = !r_ov || o_rsp.ready;
    assign o_run    = (r_state != ST_CLEAR);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        unique case (it.mode)
            M_ZP:    ea = {8'd0, it.lo};
            M_ZPX:   ea = {8'd0, 8'(it.lo + r_x)};
            M_ZPY:   ea = {8'd0, 8'(it.lo + r_y)};
            M_ABSX:  ea = 16'(abs16 + {8'd0, r_x});
            M_ABSY:  ea = 16'(abs16 + {8'd0, r_y});
            default: ea = abs16;
        endcase
        needs_rd = (it.mode != M_IMM) &&
                   (it.kind == K_BIT || it.kind == K_ADC || it.kind == K_LD ||
                    it.kind == K_INC);
        unique case (it.rsel)
            R_X:     rv = r_x;
            R_Y:     rv = r_y;
            default: rv = r_a;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc = r_pc; n_a = r_a; n_x = r_x; n_y = r_y; n_p = r_p; n_sp = r_sp;
        n_ptr = r_ptr; n_ea = r_ea; n_cur = r_cur; n_clr = r_clr;
        n_ov = r_ov && !o_rsp.ready;
        n_out = r_out;
        we = 1'b0; wa = '0; wd = '0; ra = '0;
        o_pop = 1'b0;
        fin = 1'b0;
        sv = 1'b0;
        sd = '0;
        m = (r_state == ST_MEMRD) ? rd : it.lo;
        sum8 = 8'(m + 8'd1);
        adc_s = {1'b0, r_a} + {1'b0, m} + {8'd0, r_p[FL_C]};

        unique case (r_state)
            ST_CLEAR: begin
                we = 1'b1; wa = r_clr;
                n_clr = MEM_AW'(r_clr + 1'b1);
                if (&r_clr) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_head_valid && out_free) begin
                    o_pop = 1'b1;
                    n_cur = i_head;
                    n_ea  = ea;
                    priority if (it.kind == K_LOAD) begin
                        we = 1'b1; wa = abs16[MEM_AW-1:0]; wd = it.data;
                        fin = 1'b1;
                    end else if (it.kind == K_BRK || it.kind == K_JSR) begin
                        we = 1'b1; wa = MEM_AW'({STACK_PAGE, r_sp}); wd = p2[15:8];
                        n_sp = 8'(r_sp - 8'd1);
                        n_state = ST_PUSH1;
                    end else if (it.mode == M_INDX || it.mode == M_INDY) begin
                        ra = MEM_AW'({8'd0, ptr});
                        n_state = ST_PTRL;
                    end else if (needs_rd) begin
                        ra = ea[MEM_AW-1:0];
                        n_state = ST_MEMRD;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            ST_PUSH1: begin
                we = 1'b1; wa = MEM_AW'({STACK_PAGE, r_sp}); wd = p2[7:0];
                n_sp = 8'(r_sp - 8'd1);
                if (it.kind == K_BRK) begin
                    n_state = ST_PUSH2;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_PUSH2: begin
                we = 1'b1; wa = MEM_AW'({STACK_PAGE, r_sp}); wd = r_p | FL_BRK_PUSH;
                n_sp = 8'(r_sp - 8'd1);
                n_p[FL_I] = 1'b1;
                ra = VEC_LO[MEM_AW-1:0];
                n_state = ST_VEC0;
            end
            ST_VEC0: begin
                n_ptr = rd;
                ra = VEC_HI[MEM_AW-1:0];
                n_state = ST_VEC1;
            end
            ST_VEC1: begin
                fin = 1'b1;
            end
            ST_PTRL: begin
                n_ptr = rd;
                ra = MEM_AW'({8'd0, 8'(ptr + 8'd1)});
                n_state = ST_PTRH;
            end
            ST_PTRH: begin
                n_ea = ind_ea;
                ra = ind_ea[MEM_AW-1:0];
                n_state = ST_MEMRD;
            end
            ST_MEMRD: begin
                fin = 1'b1;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase

        if (fin) begin
            n_state = ST_DISP;
            if (it.kind != K_LOAD) begin
                n_pc = pc_seq;
            end
            unique case (it.kind)
                K_BRK: n_pc = {rd, r_ptr};
                K_ASL: begin
                    n_p[FL_C] = r_a[7];
                    n_a = {r_a[6:0], 1'b0};
                    n_p[FL_N] = r_a[6]; n_p[FL_Z] = (r_a[6:0] == 7'd0);
                end
                K_JSR, K_JMP: n_pc = abs16;
                K_BIT: begin
                    n_p[FL_N] = m[7]; n_p[FL_V] = m[6];
                    n_p[FL_Z] = ((m & r_a) == 8'd0);
                end
                K_ADC: begin
                    n_a = adc_s[7:0];
                    n_p[FL_C] = adc_s[8];
                    n_p[FL_V] = ~(r_a[7] ^ m[7]) & (r_a[7] ^ adc_s[7]);
                    n_p[FL_N] = adc_s[7]; n_p[FL_Z] = (adc_s[7:0] == 8'd0);
                end
                K_ST: begin
                    sv = 1'b1; sd = rv;
                end
                K_LD: begin
                    unique case (it.rsel)
                        R_X:     n_x = m;
                        R_Y:     n_y = m;
                        default: n_a = m;
                    endcase
                    n_p[FL_N] = m[7]; n_p[FL_Z] = (m == 8'd0);
                end
                K_INX: begin
                    n_x = 8'(r_x + 8'd1);
                    n_p[FL_N] = n_x[7]; n_p[FL_Z] = (n_x == 8'd0);
                end
                K_INY: begin
                    n_y = 8'(r_y + 8'd1);
                    n_p[FL_N] = n_y[7]; n_p[FL_Z] = (n_y == 8'd0);
                end
                K_CPX: begin
                    n_p[FL_C] = (r_x >= it.lo);
                    n_p[FL_N] = 8'(r_x - it.lo) >> 7 != 8'd0;
                    n_p[FL_Z] = (r_x == it.lo);
                end
                K_BNE, K_BEQ: begin
                    if ((it.kind == K_BEQ) == r_p[FL_Z]) begin
                        n_pc = 16'(p2 + {{8{it.lo[7]}}, it.lo});
                    end
                end
                K_INC: begin
                    sv = 1'b1; sd = sum8;
                    n_p[FL_N] = sum8[7]; n_p[FL_Z] = (sum8 == 8'd0);
                end
                default: ;
            endcase
            if (sv) begin
                we = 1'b1;
                wa = n_ea[MEM_AW-1:0];
                wd = sd;
            end
            n_ov = 1'b1;
            n_out.next_pc       = n_pc;
            n_out.acc_value     = n_a;
            n_out.x_value       = n_x;
            n_out.y_value       = n_y;
            n_out.flags_value   = n_p;
            n_out.sp_value      = n_sp;
            n_out.store_valid   = sv;
            n_out.store_address = sv ? n_ea : 16'd0;
            n_out.store_data    = sd;
            n_out.unsupported   = (it.kind == K_UNS);
        end

        if (i_cfg.valid) begin
            n_pc = i_cfg.start_address;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_ea  <= n_ea;
        r_cur <= n_cur;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_pc    <= START_RESET;
            r_a     <= 8'd0;
            r_x     <= 8'd0;
            r_y     <= 8'd0;
            r_p     <= FLAGS_RESET;
            r_sp    <= SP_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_pc    <= n_pc;
            r_a     <= n_a;
            r_x     <= n_x;
            r_y     <= n_y;
            r_p     <= n_p;
            r_sp    <= n_sp;
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.next_pc       = r_out.next_pc;
    assign o_rsp.acc_value     = r_out.acc_value;
    assign o_rsp.x_value       = r_out.x_value;
    assign o_rsp.y_value       = r_out.y_value;
    assign o_rsp.flags_value   = r_out.flags_value;
    assign o_rsp.sp_value      = r_out.sp_value;
    assign o_rsp.store_valid   = r_out.store_valid;
    assign o_rsp.store_address = r_out.store_address;
    assign o_rsp.store_data    = r_out.store_data;
    assign o_rsp.unsupported   = r_out.unsupported;
endmodule
`default_nettype wire

FILE: rtl/core/cpu_6502_subset_execute.sv
// top level of the 6502 subset executor: front decode, queue, back execute
//
// channel  dir  carries
// i_req    in   cmd, opcode, operand_low, operand_high, load_data
// o_rsp    out  next_pc, acc/x/y/flags/sp, store_valid/address/data, unsupported
// i_cfg    in   start_address (also loads the program counter at once)
//
// register-only ops, immediates, stores, jumps, branches, loads: done at dispatch
// zero page / absolute reads and inc: a memory read state; jsr: two pushes;
// (zp,x)/(zp),y: pointer bytes, operand; brk: three pushes then two vector reads
// after reset the ram is swept to zero, address by address, with no request taken
// a two-entry queue lets decode keep taking requests while execute is busy
// a result register holds each answer; execute stalls only when it is still full
`default_nettype none
module cpu_6502_subset_execute (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    c65_req_if.sink   i_req,
    c65_rsp_if.source o_rsp,
    c65_cfg_if.sink   i_cfg
);
    import c65_pkg::*;

    logic  head_valid;
    t_item head;
    logic  pop;
    logic  run;

    // decode and queue requests
    c65_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_run        (run),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // execute, own state and memory, drive results
    c65_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_run        (run),
        .i_cfg        (i_cfg),
        .o_rsp        (o_rsp)
    );
endmodule
`default_nettype wire

FILE: test/tb.sv
// self-checking testbench for the 6502 subset executor
`default_nettype none
module tb;
    import c65_pkg::*;

    // opcodes exercised by the stimulus and the instruction model
    localparam logic [7:0] OP_BRK = 8'h00, OP_ASL = 8'h0A, OP_JSR = 8'h20, OP_JMP = 8'h4C;
    localparam logic [7:0] OP_BIT_ZP = 8'h24, OP_BIT_ABS = 8'h2C;
    localparam logic [7:0] OP_ADC_IMM = 8'h69, OP_ADC_ZP = 8'h65, OP_ADC_ABS = 8'h6D;
    localparam logic [7:0] OP_ADC_INDX = 8'h61, OP_ADC_INDY = 8'h71;
    localparam logic [7:0] OP_STY_ZP = 8'h84, OP_STY_ABS = 8'h8C;
    localparam logic [7:0] OP_STA_ZP = 8'h85, OP_STA_ABS = 8'h8D;
    localparam logic [7:0] OP_STA_ZPX = 8'h95, OP_STA_ABSX = 8'h9D;
    localparam logic [7:0] OP_STX_ZP = 8'h86, OP_STX_ABS = 8'h8E;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0, OP_LDY_ZP = 8'hA4, OP_LDY_ABS = 8'hAC;
    localparam logic [7:0] OP_LDY_ZPX = 8'hB4;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2, OP_LDX_ZP = 8'hA6, OP_LDX_ABS = 8'hAE;
    localparam logic [7:0] OP_LDX_ZPY = 8'hB6;
    localparam logic [7:0] OP_LDA_IMM = 8'hA9, OP_LDA_ZP = 8'hA5, OP_LDA_ABS = 8'hAD;
    localparam logic [7:0] OP_LDA_INDX = 8'hA1, OP_LDA_INDY = 8'hB1, OP_LDA_ZPX = 8'hB5;
    localparam logic [7:0] OP_LDA_ABSY = 8'hB9, OP_LDA_ABSX = 8'hBD;
    localparam logic [7:0] OP_INY = 8'hC8, OP_INX = 8'hE8, OP_CPX = 8'hE0;
    localparam logic [7:0] OP_BNE = 8'hD0, OP_BEQ = 8'hF0, OP_NOP = 8'hEA;
    localparam logic [7:0] OP_INC_ZP = 8'hE6, OP_INC_ABS = 8'hEE;
    localparam logic [7:0] OP_INC_ZPX = 8'hF6, OP_INC_ABSX = 8'hFE;
    localparam logic [7:0] OP_UNDEF = 8'h02;
    localparam bit CMD_EXEC = 1'b0, CMD_LOAD = 1'b1;

    localparam int IDLE_LIMIT  = 200000; // covers the ram clear after reset
    localparam int DRAIN_WAIT  = 20;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        bit       cmd;
        bit [7:0] opcode;
        bit [7:0] lo;
        bit [7:0] hi;
        bit [7:0] data;
    } t_cpu_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    c65_req_if req_bus ();
    c65_rsp_if rsp_bus ();
    c65_cfg_if cfg_bus ();

    cpu_6502_subset_execute i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    always #5 i_clk = ~i_clk;

    // architectural copy kept by the testbench
    logic [15:0] arch_pc;
    logic [7:0]  arch_a, arch_x, arch_y, arch_p, arch_sp;
    logic [7:0]  mem_img [0:MEM_DEPTH-1];

    t_cpu_req pending_reqs[$];
    t_result  expected_states[$];
    int       n_fail = 0;
    int       n_issued = 0;
    int       n_checked = 0;
    int       n_stores = 0;
    int       n_uns = 0;
    bit       burst_mode = 1'b0;

    logic [7:0] supported_ops[$] = '{
        OP_BRK, OP_ASL, OP_JSR, OP_JMP, OP_BIT_ZP, OP_BIT_ABS, OP_ADC_IMM, OP_ADC_ZP,
        OP_ADC_ABS, OP_ADC_INDX, OP_ADC_INDY, OP_STY_ZP, OP_STY_ABS, OP_STA_ZP,
        OP_STA_ABS, OP_STA_ZPX, OP_STA_ABSX, OP_STX_ZP, OP_STX_ABS, OP_LDY_IMM,
        OP_LDY_ZP, OP_LDY_ABS, OP_LDY_ZPX, OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ABS,
        OP_LDX_ZPY, OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ABS, OP_LDA_INDX, OP_LDA_INDY,
        OP_LDA_ZPX, OP_LDA_ABSY, OP_LDA_ABSX, OP_INY, OP_INX, OP_CPX, OP_BNE,
        OP_BEQ, OP_NOP, OP_INC_ZP, OP_INC_ABS, OP_INC_ZPX, OP_INC_ABSX
    };

    function automatic logic [7:0] mem_read(logic [15:0] addr);
        return mem_img[addr % MEM_DEPTH];
    endfunction

    function automatic void mem_write(logic [15:0] addr, logic [7:0] val);
        mem_img[addr % MEM_DEPTH] = val;
    endfunction

    function automatic void stack_push(logic [7:0] val);
        mem_write({STACK_PAGE, arch_sp}, val);
        arch_sp = arch_sp - 8'd1;
    endfunction

    function automatic void update_nz(logic [7:0] val);
        arch_p[FL_Z] = (val == 8'h00);
        arch_p[FL_N] = val[7];
    endfunction

    function automatic void add_with_carry(logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, arch_a} + {1'b0, m} + {8'h00, arch_p[FL_C]};
        arch_p[FL_C] = sum[8];
        arch_p[FL_V] = ~(arch_a[7] ^ m[7]) & (arch_a[7] ^ sum[7]);
        arch_a = sum[7:0];
        update_nz(arch_a);
    endfunction

    // instruction model: advances the copied state and returns the expected result
    function automatic t_result execute_instr(t_cpu_req r);
        t_result     res;
        logic [15:0] abs16, p1, p2, p3, npc, ea, indx, indy, absx, absy;
        logic [7:0]  zpx, zpy, m, st;
        res   = '0;
        abs16 = {r.hi, r.lo};
        if (r.cmd == CMD_LOAD) begin
            mem_write(abs16, r.data);
        end else begin
            zpx  = r.lo + arch_x;
            zpy  = r.lo + arch_y;
            absx = abs16 + {8'h00, arch_x};
            absy = abs16 + {8'h00, arch_y};
            // pointer fetches stay in page zero
            indx = {mem_read({8'h00, zpx + 8'd1}), mem_read({8'h00, zpx})};
            indy = {mem_read({8'h00, r.lo + 8'd1}), mem_read({8'h00, r.lo})}
                   + {8'h00, arch_y};
            p1   = arch_pc + 16'd1;
            p2   = arch_pc + 16'd2;
            p3   = arch_pc + 16'd3;
            npc  = p2;
            st   = 8'h00;
            ea   = 16'h0000;
            case (r.opcode)
                OP_BRK: begin
                    stack_push(p2[15:8]);
                    stack_push(p2[7:0]);
                    stack_push(arch_p | FL_BRK_PUSH);
                    arch_p[FL_I] = 1'b1;
                    npc = {mem_read(VEC_HI), mem_read(VEC_LO)};
                end
                OP_ASL: begin
                    arch_p[FL_C] = arch_a[7];
                    arch_a = {arch_a[6:0], 1'b0};
                    update_nz(arch_a);
                    npc = p1;
                end
                OP_JSR: begin
                    stack_push(p2[15:8]);
                    stack_push(p2[7:0]);
                    npc = abs16;
                end
                OP_JMP: npc = abs16;
                OP_BIT_ZP, OP_BIT_ABS: begin
                    m = mem_read(r.opcode == OP_BIT_ZP ? {8'h00, r.lo} : abs16);
                    arch_p[FL_N] = m[7];
                    arch_p[FL_V] = m[6];
                    arch_p[FL_Z] = ((m & arch_a) == 8'h00);
                    if (r.opcode == OP_BIT_ABS) npc = p3;
                end
                OP_ADC_IMM:  add_with_carry(r.lo);
                OP_ADC_ZP:   add_with_carry(mem_read({8'h00, r.lo}));
                OP_ADC_ABS: begin
                    add_with_carry(mem_read(abs16));
                    npc = p3;
                end
                OP_ADC_INDX: add_with_carry(mem_read(indx));
                OP_ADC_INDY: add_with_carry(mem_read(indy));
                OP_STY_ZP, OP_STY_ABS, OP_STA_ZP, OP_STA_ABS, OP_STA_ZPX, OP_STA_ABSX,
                OP_STX_ZP, OP_STX_ABS: begin
                    if (r.opcode == OP_STY_ZP || r.opcode == OP_STY_ABS) st = arch_y;
                    else if (r.opcode == OP_STX_ZP || r.opcode == OP_STX_ABS) st = arch_x;
                    else st = arch_a;
                    case (r.opcode)
                        OP_STA_ZPX:                        ea = {8'h00, zpx};
                        OP_STA_ABSX:                       ea = absx;
                        OP_STY_ZP, OP_STA_ZP, OP_STX_ZP:   ea = {8'h00, r.lo};
                        default:                           ea = abs16;
                    endcase
                    if (r.opcode inside {OP_STY_ABS, OP_STA_ABS, OP_STX_ABS, OP_STA_ABSX})
                        npc = p3;
                    mem_write(ea, st);
                    res.store_valid = 1'b1;
                end
                OP_LDY_IMM: begin arch_y = r.lo; update_nz(arch_y); end
                OP_LDY_ZP:  begin arch_y = mem_read({8'h00, r.lo}); update_nz(arch_y); end
                OP_LDY_ABS: begin
                    arch_y = mem_read(abs16); update_nz(arch_y); npc = p3;
                end
                OP_LDY_ZPX: begin arch_y = mem_read({8'h00, zpx}); update_nz(arch_y); end
                OP_LDX_IMM: begin arch_x = r.lo; update_nz(arch_x); end
                OP_LDX_ZP:  begin arch_x = mem_read({8'h00, r.lo}); update_nz(arch_x); end
                OP_LDX_ABS: begin
                    arch_x = mem_read(abs16); update_nz(arch_x); npc = p3;
                end
                OP_LDX_ZPY: begin arch_x = mem_read({8'h00, zpy}); update_nz(arch_x); end
                OP_LDA_IMM: begin arch_a = r.lo; update_nz(arch_a); end
                OP_LDA_ZP:  begin arch_a = mem_read({8'h00, r.lo}); update_nz(arch_a); end
                OP_LDA_ABS: begin
                    arch_a = mem_read(abs16); update_nz(arch_a); npc = p3;
                end
                OP_LDA_INDX: begin arch_a = mem_read(indx); update_nz(arch_a); end
                OP_LDA_INDY: begin arch_a = mem_read(indy); update_nz(arch_a); end
                OP_LDA_ZPX:  begin arch_a = mem_read({8'h00, zpx}); update_nz(arch_a); end
                OP_LDA_ABSY: begin arch_a = mem_read(absy); update_nz(arch_a); npc = p3; end
                OP_LDA_ABSX: begin arch_a = mem_read(absx); update_nz(arch_a); npc = p3; end
                OP_INY: begin arch_y = arch_y + 8'd1; update_nz(arch_y); npc = p1; end
                OP_INX: begin arch_x = arch_x + 8'd1; update_nz(arch_x); npc = p1; end
                OP_CPX: begin
                    arch_p[FL_C] = (arch_x >= r.lo);
                    update_nz(arch_x - r.lo);
                end
                OP_BNE, OP_BEQ: begin
                    if ((r.opcode == OP_BEQ) == arch_p[FL_Z])
                        npc = p2 + {{8{r.lo[7]}}, r.lo};
                end
                OP_NOP: npc = p1;
                OP_INC_ZP, OP_INC_ABS, OP_INC_ZPX, OP_INC_ABSX: begin
                    case (r.opcode)
                        OP_INC_ZP:  ea = {8'h00, r.lo};
                        OP_INC_ZPX: ea = {8'h00, zpx};
                        OP_INC_ABS: begin ea = abs16; npc = p3; end
                        default:    begin ea = absx; npc = p3; end
                    endcase
                    st = mem_read(ea) + 8'd1;
                    mem_write(ea, st);
                    update_nz(st);
                    res.store_valid = 1'b1;
                end
                default: begin
                    res.unsupported = 1'b1;
                    npc = p1;
                end
            endcase
            if (res.store_valid) begin
                res.store_address = ea;
                res.store_data    = st;
            end
            arch_pc = npc;
        end
        res.next_pc     = arch_pc;
        res.acc_value   = arch_a;
        res.x_value     = arch_x;
        res.y_value     = arch_y;
        res.flags_value = arch_p;
        res.sp_value    = arch_sp;
        return res;
    endfunction

    // request driver: random idle gaps between requests, none in a burst stretch
    t_cpu_req cur_req;
    int       req_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                expected_states.push_back(execute_instr(cur_req));
                n_issued++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_bus.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    req_bus.valid        <= 1'b1;
                    req_bus.cmd          <= cur_req.cmd;
                    req_bus.opcode       <= cur_req.opcode;
                    req_bus.operand_low  <= cur_req.lo;
                    req_bus.operand_high <= cur_req.hi;
                    req_bus.load_data    <= cur_req.data;
                    req_gap = burst_mode ? 0 : $urandom_range(0, 5);
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls and one long hold-off
    int  rsp_stall = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    t_result exp_r;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_states.size() == 0) begin
                    $error("result with nothing expected, next_pc %h", rsp_bus.next_pc);
                    n_fail++;
                end else begin
                    exp_r = expected_states.pop_front();
                    n_checked++;
                    if (exp_r.store_valid) n_stores++;
                    if (exp_r.unsupported) n_uns++;
                    if (rsp_bus.next_pc !== exp_r.next_pc) begin
                        $error("next_pc exp %h got %h", exp_r.next_pc, rsp_bus.next_pc);
                        n_fail++;
                    end
                    if (rsp_bus.acc_value !== exp_r.acc_value) begin
                        $error("acc_value exp %h got %h", exp_r.acc_value, rsp_bus.acc_value);
                        n_fail++;
                    end
                    if (rsp_bus.x_value !== exp_r.x_value) begin
                        $error("x_value exp %h got %h", exp_r.x_value, rsp_bus.x_value);
                        n_fail++;
                    end
                    if (rsp_bus.y_value !== exp_r.y_value) begin
                        $error("y_value exp %h got %h", exp_r.y_value, rsp_bus.y_value);
                        n_fail++;
                    end
                    if (rsp_bus.flags_value !== exp_r.flags_value) begin
                        $error("flags_value exp %h got %h", exp_r.flags_value,
                               rsp_bus.flags_value);
                        n_fail++;
                    end
                    if (rsp_bus.sp_value !== exp_r.sp_value) begin
                        $error("sp_value exp %h got %h", exp_r.sp_value, rsp_bus.sp_value);
                        n_fail++;
                    end
                    if (rsp_bus.store_valid !== exp_r.store_valid) begin
                        $error("store_valid exp %h got %h", exp_r.store_valid,
                               rsp_bus.store_valid);
                        n_fail++;
                    end
                    if (rsp_bus.store_address !== exp_r.store_address) begin
                        $error("store_address exp %h got %h", exp_r.store_address,
                               rsp_bus.store_address);
                        n_fail++;
                    end
                    if (rsp_bus.store_data !== exp_r.store_data) begin
                        $error("store_data exp %h got %h", exp_r.store_data,
                               rsp_bus.store_data);
                        n_fail++;
                    end
                    if (rsp_bus.unsupported !== exp_r.unsupported) begin
                        $error("unsupported exp %h got %h", exp_r.unsupported,
                               rsp_bus.unsupported);
                        n_fail++;
                    end
                end
                rsp_stall = burst_mode ? 0 : $urandom_range(0, 5);
                if (!hold_done && n_checked == 100) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (rsp_stall > 0) begin
                rsp_stall--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    function automatic void queue_req(bit cmd, logic [7:0] op, logic [7:0] lo,
                                      logic [7:0] hi, logic [7:0] data);
        t_cpu_req r;
        r.cmd = cmd; r.opcode = op; r.lo = lo; r.hi = hi; r.data = data;
        pending_reqs.push_back(r);
    endfunction

    // random request: mostly instructions over a small address window so that
    // loads, stores and reads hit the same bytes
    function automatic void queue_random_req();
        int         pick;
        logic [7:0] lo, hi;
        pick = $urandom_range(0, 99);
        lo   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        hi   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        if (pick < 20)
            queue_req(CMD_LOAD, 8'($urandom), lo, hi, 8'($urandom));
        else if (pick < 28)
            queue_req(CMD_EXEC, 8'($urandom), lo, hi, 8'($urandom));
        else
            queue_req(CMD_EXEC, supported_ops[$urandom_range(0, supported_ops.size() - 1)],
                      lo, hi, 8'($urandom));
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req_bus.valid || expected_states.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_start(logic [15:0] addr);
        cfg_bus.valid         <= 1'b1;
        cfg_bus.start_address <= addr;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        arch_pc = addr;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_random(int count);
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            queue_random_req();
        end
        wait_idle();
        burst_mode = 1'b0;
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.start_address <= 16'h0000;
        arch_pc = START_RESET;
        arch_a  = 8'h00;
        arch_x  = 8'h00;
        arch_y  = 8'h00;
        arch_p  = FLAGS_RESET;
        arch_sp = SP_RESET;
        for (int k = 0; k < MEM_DEPTH; k++) mem_img[k] = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: vectors, pointers, several addressing modes, flag corner cases
        queue_req(CMD_LOAD, OP_NOP, 8'hFE, 8'hFF, 8'h34);       // brk vector
        queue_req(CMD_LOAD, OP_UNDEF, 8'hFF, 8'hFF, 8'h12);
        queue_req(CMD_LOAD, OP_NOP, 8'hFF, 8'h00, 8'h00);       // pointer across page wrap
        queue_req(CMD_LOAD, OP_NOP, 8'h00, 8'h00, 8'h03);
        queue_req(CMD_LOAD, OP_NOP, 8'hFF, 8'h03, 8'hC0);
        queue_req(CMD_EXEC, OP_LDA_IMM, 8'h00, 8'h00, 8'h00);   // zero flag
        queue_req(CMD_EXEC, OP_LDA_IMM, 8'h7F, 8'h00, 8'h00);
        queue_req(CMD_EXEC, OP_ADC_IMM, 8'h01, 8'h00, 8'h00);   // signed overflow
        queue_req(CMD_EXEC, OP_ASL, 8'h00, 8'h00, 8'h00);       // carry out
        queue_req(CMD_EXEC, OP_ADC_IMM, 8'hFF, 8'h00, 8'h00);
        queue_req(CMD_EXEC, OP_LDX_IMM, 8'hFF, 8'h00, 8'h00);
        queue_req(CMD_EXEC, OP_LDA_INDX, 8'h00, 8'h00, 8'h00);  // (zp,x) wrapping to ff
        queue_req(CMD_EXEC, OP_LDY_IMM, 8'hFF, 8'h00, 8'h00);
        queue_req(CMD_EXEC, OP_LDA_INDY, 8'hFF, 8'h00, 8'h00);  // (zp),y with wraps
        queue_req(CMD_EXEC, OP_BIT_ABS, 8'hFF, 8'h03, 8'h00);
        queue_req(CMD_EXEC, OP_STA_ABSX, 8'hFF, 8'hFF, 8'h00);  // absolute,x wraps at 16 bits
        queue_req(CMD_EXEC, OP_INC_ZPX, 8'h05, 8'h00, 8'h00);   // zero page,x wraps
        queue_req(CMD_EXEC, OP_INX, 8'h00, 8'h00, 8'h00);       // x wraps to zero
        queue_req(CMD_EXEC, OP_CPX, 8'h01, 8'h00, 8'h00);
        queue_req(CMD_EXEC, OP_BNE, 8'h80, 8'h00, 8'h00);       // backward branch
        queue_req(CMD_EXEC, OP_BEQ, 8'h7F, 8'h00, 8'h00);
        queue_req(CMD_EXEC, OP_JSR, 8'hFE, 8'hFF, 8'h00);
        queue_req(CMD_EXEC, OP_BRK, 8'h00, 8'h00, 8'h00);
        queue_req(CMD_EXEC, OP_JMP, 8'h00, 8'h00, 8'h00);
        queue_req(CMD_EXEC, OP_UNDEF, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // random phases across several start addresses, extremes included
        write_start(16'h0000);
        run_random(170);
        write_start(16'hFFFF);
        run_random(170);
        write_start(16'($urandom));
        run_random(170);

        $display("requests %0d, results checked %0d, stores %0d, unsupported %0d",
                 n_issued, n_checked, n_stores, n_uns);
        $display("start address set to reset value, 0000, ffff and a random value");
        if (n_fail == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
